### hdl/qnlerp_pkg.sv
package qnlerp_pkg;

   localparam int COMPONENT_BITS = 16;
   localparam int FRAC_WIDTH     = 17;
   localparam int FRAC_BITS      = 16;
   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = FRAC_WIDTH'(1) << FRAC_BITS;

   localparam int PROD_W  = 2 * COMPONENT_BITS;
   localparam int DOT_W   = PROD_W + 2;
   localparam int DIFF_W  = COMPONENT_BITS + 2;
   localparam int LERP_W  = COMPONENT_BITS + 19;
   localparam int MAG_W   = LERP_W - 1;
   localparam int POS_W   = $clog2(MAG_W);
   localparam int NORM_W  = 30;
   localparam int NORM_TOP = NORM_W - 1;
   localparam int SQ_W    = 2 * NORM_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int DVS_W   = ROOT_W + 1;
   localparam int NUM_W   = COMPONENT_BITS + NORM_W;
   localparam int QUO_W   = COMPONENT_BITS - 1;

   typedef logic signed [COMPONENT_BITS-1:0] comp_type;

   typedef struct packed {
      comp_type               start_w;
      comp_type               start_x;
      comp_type               start_y;
      comp_type               start_z;
      comp_type               end_w;
      comp_type               end_x;
      comp_type               end_y;
      comp_type               end_z;
      logic [FRAC_WIDTH-1:0]  fraction;
   } req_type;

   typedef struct packed {
      comp_type out_w;
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
      logic     zero_length;
   } rsp_type;

   // one step of the square root pipeline
   typedef struct packed {
      logic [3:0]              neg;
      logic                    zero;
      logic [3:0][NORM_W-1:0]  mag;
      logic [SUM_W-1:0]        sum;
      logic [REM_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
   } sqrt_type;

   // one step of the four-lane divider pipeline
   typedef struct packed {
      logic [3:0]             neg;
      logic                   zero;
      logic [3:0][NUM_W-1:0]  rem;
      logic [DVS_W-1:0]       dvs;
      logic [3:0][QUO_W-1:0]  quo;
   } div_type;

endpackage

### hdl/quaternion_normalized_lerp.sv
// Channel   Handshake                Payload
// req       start / busy             req_data (qnlerp_pkg::req_type)
// rsp       rsp_valid (strobe)       rsp_data (qnlerp_pkg::rsp_type)
// csr       csr_valid / csr_ready    csr_data (shortest_path)
//
// One item enters every cycle; busy is always low. A result passes
// stages A to H, the one-bit-per-stage square root, the divider entry,
// the one-bit-per-stage divider and the output register.
// Synchronous reset clears the valid pipeline and shortest_path.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_normalized_lerp (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qnlerp_pkg::req_type req_data,
   output logic                rsp_valid,
   output qnlerp_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);

   localparam int B     = qnlerp_pkg::COMPONENT_BITS;
   localparam int RW    = qnlerp_pkg::ROOT_W;
   localparam int QW    = qnlerp_pkg::QUO_W;
   localparam int SQ0   = 7;
   localparam int DV0   = 8 + RW;
   localparam int LAT   = 10 + RW + QW;

   logic             sp_ff;
   logic [LAT-1:0]   vld_ff, vld_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= 1'b0;
         vld_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            sp_ff <= csr_data;
         end
         vld_ff <= vld_in;
      end
   end

   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   // stage A: unpack, clamp fraction, component products
   qnlerp_pkg::comp_type                 pa_ff [4];
   qnlerp_pkg::comp_type                 qa_ff [4];
   logic signed [qnlerp_pkg::PROD_W-1:0] prod_ff [4];
   logic [qnlerp_pkg::FRAC_WIDTH-1:0]    ta_ff;
   qnlerp_pkg::comp_type                 pa_in [4];
   qnlerp_pkg::comp_type                 qa_in [4];

   always_comb begin
      pa_in[0] = req_data.start_w;
      pa_in[1] = req_data.start_x;
      pa_in[2] = req_data.start_y;
      pa_in[3] = req_data.start_z;
      qa_in[0] = req_data.end_w;
      qa_in[1] = req_data.end_x;
      qa_in[2] = req_data.end_y;
      qa_in[3] = req_data.end_z;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         pa_ff[i]   <= pa_in[i];
         qa_ff[i]   <= qa_in[i];
         prod_ff[i] <= qnlerp_pkg::PROD_W'(pa_in[i]) * qnlerp_pkg::PROD_W'(qa_in[i]);
      end
      ta_ff <= (req_data.fraction > qnlerp_pkg::FRAC_ONE) ? qnlerp_pkg::FRAC_ONE
                                                          : req_data.fraction;
   end

   // stage B: dot sign, flip end quaternion if shortest_path, difference
   qnlerp_pkg::comp_type                 pb_ff [4];
   logic signed [qnlerp_pkg::DIFF_W-1:0] db_ff [4];
   logic [qnlerp_pkg::FRAC_WIDTH-1:0]    tb_ff;

   always_ff @(posedge clock) begin
      logic signed [qnlerp_pkg::DOT_W-1:0]  dot;
      logic                                 flip;
      logic signed [qnlerp_pkg::DIFF_W-1:0] qe;
      dot = '0;
      for (int i = 0; i < 4; i++) begin
         dot = dot + qnlerp_pkg::DOT_W'(prod_ff[i]);
      end
      flip = sp_ff & dot[qnlerp_pkg::DOT_W-1];
      for (int i = 0; i < 4; i++) begin
         qe = qnlerp_pkg::DIFF_W'(qa_ff[i]);
         if (flip) begin
            qe = -qe;
         end
         pb_ff[i] <= pa_ff[i];
         db_ff[i] <= qe - qnlerp_pkg::DIFF_W'(pa_ff[i]);
      end
      tb_ff <= ta_ff;
   end

   // stage C: lerp
   logic signed [qnlerp_pkg::LERP_W-1:0] vc_ff [4];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         vc_ff[i] <= (qnlerp_pkg::LERP_W'(pb_ff[i]) <<< qnlerp_pkg::FRAC_BITS)
                   + qnlerp_pkg::LERP_W'(db_ff[i])
                   * qnlerp_pkg::LERP_W'($signed({1'b0, tb_ff}));
      end
   end

   // stage D: magnitudes and their OR (same top bit as the maximum)
   logic [qnlerp_pkg::MAG_W-1:0] md_ff [4];
   logic [3:0]                   nd_ff;
   logic [qnlerp_pkg::MAG_W-1:0] od_ff;

   always_ff @(posedge clock) begin
      logic [qnlerp_pkg::MAG_W-1:0] m;
      logic [qnlerp_pkg::MAG_W-1:0] o;
      o = '0;
      for (int i = 0; i < 4; i++) begin
         m = vc_ff[i][qnlerp_pkg::LERP_W-1] ? qnlerp_pkg::MAG_W'(-vc_ff[i])
                                            : qnlerp_pkg::MAG_W'(vc_ff[i]);
         o = o | m;
         md_ff[i] <= m;
         nd_ff[i] <= vc_ff[i][qnlerp_pkg::LERP_W-1];
      end
      od_ff <= o;
   end

   // stage E: leading one position
   logic [qnlerp_pkg::MAG_W-1:0] me_ff [4];
   logic [3:0]                   ne_ff;
   logic [qnlerp_pkg::POS_W-1:0] pos_ff;
   logic                         ze_ff;

   always_ff @(posedge clock) begin
      logic [qnlerp_pkg::POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < qnlerp_pkg::MAG_W; i++) begin
         if (od_ff[i]) begin
            p = qnlerp_pkg::POS_W'(i);
         end
      end
      pos_ff <= p;
      ze_ff  <= (od_ff == '0);
      ne_ff  <= nd_ff;
      for (int i = 0; i < 4; i++) begin
         me_ff[i] <= md_ff[i];
      end
   end

   // stage F: common shift into [2^29, 2^30)
   logic [qnlerp_pkg::NORM_W-1:0] af_ff [4];
   logic [3:0]                    nf_ff;
   logic                          zf_ff;

   always_ff @(posedge clock) begin
      logic [qnlerp_pkg::MAG_W+qnlerp_pkg::NORM_W-1:0] ext;
      for (int i = 0; i < 4; i++) begin
         ext = (qnlerp_pkg::MAG_W + qnlerp_pkg::NORM_W)'(me_ff[i]);
         if (pos_ff >= qnlerp_pkg::POS_W'(qnlerp_pkg::NORM_TOP)) begin
            ext = ext >> (pos_ff - qnlerp_pkg::POS_W'(qnlerp_pkg::NORM_TOP));
         end else begin
            ext = ext << (qnlerp_pkg::POS_W'(qnlerp_pkg::NORM_TOP) - pos_ff);
         end
         af_ff[i] <= ext[qnlerp_pkg::NORM_W-1:0];
      end
      nf_ff <= ne_ff;
      zf_ff <= ze_ff;
   end

   // stage G: squares
   logic [qnlerp_pkg::SQ_W-1:0]   sg_ff [4];
   logic [qnlerp_pkg::NORM_W-1:0] ag_ff [4];
   logic [3:0]                    ng_ff;
   logic                          zg_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         sg_ff[i] <= qnlerp_pkg::SQ_W'(af_ff[i]) * qnlerp_pkg::SQ_W'(af_ff[i]);
         ag_ff[i] <= af_ff[i];
      end
      ng_ff <= nf_ff;
      zg_ff <= zf_ff;
   end

   // stage H: sum of squares, enter square root
   qnlerp_pkg::sqrt_type sq_ff [RW+1];

   always_ff @(posedge clock) begin
      sq_ff[0].sum <= qnlerp_pkg::SUM_W'(sg_ff[0]) + qnlerp_pkg::SUM_W'(sg_ff[1])
                    + qnlerp_pkg::SUM_W'(sg_ff[2]) + qnlerp_pkg::SUM_W'(sg_ff[3]);
      for (int i = 0; i < 4; i++) begin
         sq_ff[0].mag[i] <= ag_ff[i];
      end
      sq_ff[0].neg  <= ng_ff;
      sq_ff[0].zero <= zg_ff;
      sq_ff[0].rem  <= '0;
      sq_ff[0].root <= '0;
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      localparam int J = RW - 1 - k;
      qnlerp_pkg::sqrt_type sq_in;

      always_comb begin
         logic [qnlerp_pkg::REM_W+1:0] r;
         logic [qnlerp_pkg::REM_W+1:0] trial;
         sq_in = sq_ff[k];
         r     = {sq_ff[k].rem, sq_ff[k].sum[2*J+1 -: 2]};
         trial = {2'b00, sq_ff[k].root, 2'b01};
         if (r >= trial) begin
            r          = r - trial;
            sq_in.root = {sq_ff[k].root[RW-2:0], 1'b1};
         end else begin
            sq_in.root = {sq_ff[k].root[RW-2:0], 1'b0};
         end
         sq_in.rem = r[qnlerp_pkg::REM_W-1:0];
      end

      always_ff @(posedge clock) begin
         sq_ff[k+1] <= sq_in;
      end
   end

   // divider entry: numerator 2*a*2^(B-2) + L, divisor 2*L
   qnlerp_pkg::div_type dv_ff [QW+1];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         dv_ff[0].rem[i] <= (qnlerp_pkg::NUM_W'(sq_ff[RW].mag[i]) << (B - 1))
                          + qnlerp_pkg::NUM_W'(sq_ff[RW].root);
      end
      dv_ff[0].dvs  <= {sq_ff[RW].root, 1'b0};
      dv_ff[0].neg  <= sq_ff[RW].neg;
      dv_ff[0].zero <= sq_ff[RW].zero;
      dv_ff[0].quo  <= '0;
   end

   // restoring division, one quotient bit per stage, four lanes
   for (genvar s = 0; s < QW; s++) begin : g_div
      localparam int QB = QW - 1 - s;
      qnlerp_pkg::div_type dv_in;

      always_comb begin
         logic [qnlerp_pkg::NUM_W-1:0] d;
         dv_in = dv_ff[s];
         d     = qnlerp_pkg::NUM_W'(dv_ff[s].dvs) << QB;
         for (int i = 0; i < 4; i++) begin
            if (dv_ff[s].rem[i] >= d) begin
               dv_in.rem[i]     = dv_ff[s].rem[i] - d;
               dv_in.quo[i][QB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         dv_ff[s+1] <= dv_in;
      end
   end

   // output: sign, zero-length override
   qnlerp_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      qnlerp_pkg::comp_type c [4];
      for (int i = 0; i < 4; i++) begin
         c[i] = qnlerp_pkg::comp_type'({1'b0, dv_ff[QW].quo[i]});
         if (dv_ff[QW].zero) begin
            c[i] = '0;
         end else if (dv_ff[QW].neg[i]) begin
            c[i] = -c[i];
         end
      end
      rsp_ff.out_w       <= c[0];
      rsp_ff.out_x       <= c[1];
      rsp_ff.out_y       <= c[2];
      rsp_ff.out_z       <= c[3];
      rsp_ff.zero_length <= dv_ff[QW].zero;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = vld_ff[LAT-1];

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.out_w == '0 && rsp_data.out_x == '0 &&
         rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("zero-length result with nonzero components");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQ0] && !sq_ff[0].zero |->
         (sq_ff[0].mag[0][qnlerp_pkg::NORM_TOP] || sq_ff[0].mag[1][qnlerp_pkg::NORM_TOP] ||
          sq_ff[0].mag[2][qnlerp_pkg::NORM_TOP] || sq_ff[0].mag[3][qnlerp_pkg::NORM_TOP]))
      else $error("normalize shift missed the top bit");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DV0-1] && !sq_ff[RW].zero |->
         sq_ff[RW].root >= qnlerp_pkg::ROOT_W'(sq_ff[RW].mag[0]) &&
         sq_ff[RW].root >= qnlerp_pkg::ROOT_W'(sq_ff[RW].mag[1]) &&
         sq_ff[RW].root >= qnlerp_pkg::ROOT_W'(sq_ff[RW].mag[2]) &&
         sq_ff[RW].root >= qnlerp_pkg::ROOT_W'(sq_ff[RW].mag[3]))
      else $error("length below a component magnitude");

endmodule
